FILE: rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Holds the table size, the record layout, the operation and status codes,
// and the control and flag bundles that pass between the controller and cells.
// ----------------------------------------------------------------------------
package skt_pkg;

   // Table size and field widths.
   localparam int CAPACITY = 64;
   localparam int IDX_W    = 6;
   localparam int COUNT_W  = 7;
   localparam int KEY_W    = 32;
   localparam int QTR_W    = 16;
   localparam int SUM_W    = 18;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_FIND_KEY = 2'd2,
      OP_FIND_SUM = 2'd3
   } op_type;

   // Status codes carried on the response channel.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DUP     = 2'd1,
      STATUS_MISSING = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   // One table record.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [4*QTR_W-1:0] counts;
      logic [SUM_W-1:0]   sum;
   } record_type;

   // Compare flags held in each cell and shifted toward position zero on a scan.
   typedef struct packed {
      logic hit;
      logic gt;
   } flag_type;

   // Broadcast control from the controller to every cell.
   typedef struct packed {
      logic             load;
      logic             by_sum;
      logic [KEY_W-1:0] want_key;
      logic [SUM_W-1:0] want_sum;
      logic             scan;
      logic             ins;
      logic             del;
      logic [IDX_W-1:0] pos;
      record_type       new_rec;
   } cell_ctrl_type;

endpackage

FILE: rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one position of the sorted key table
// Stores one record and its compare flags. On an insert or delete the record
// moves one place along the chain; during a scan the flags move toward zero.
// ----------------------------------------------------------------------------
module skt_cell (
   input  logic                        clock,
   input  logic [skt_pkg::IDX_W-1:0]   my_pos,
   input  skt_pkg::cell_ctrl_type      ctrl,
   input  skt_pkg::record_type         left_rec,
   input  skt_pkg::record_type         right_rec,
   input  skt_pkg::flag_type           right_flags,
   output skt_pkg::record_type         rec,
   output skt_pkg::flag_type           flags
);

   skt_pkg::record_type rec_ff, rec_in;
   skt_pkg::flag_type   flags_ff, flags_in;

   // Record movement: open a gap on insert, close it on delete.
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.ins) begin
         if (my_pos == ctrl.pos) begin
            rec_in = ctrl.new_rec;
         end else if (my_pos > ctrl.pos) begin
            rec_in = left_rec;
         end
      end else if (ctrl.del) begin
         if (my_pos >= ctrl.pos) begin
            rec_in = right_rec;
         end
      end
   end

   // Flags are computed when a beat is taken and shift down while scanning.
   always_comb begin
      flags_in = flags_ff;
      if (ctrl.load) begin
         flags_in.hit = ctrl.by_sum ? (rec_ff.sum == ctrl.want_sum)
                                    : (rec_ff.key == ctrl.want_key);
         flags_in.gt  = rec_ff.key > ctrl.want_key;
      end else if (ctrl.scan) begin
         flags_in = right_flags;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff   <= rec_in;
      flags_ff <= flags_in;
   end

   assign rec   = rec_ff;
   assign flags = flags_ff;

endmodule

FILE: rtl/sorted_key_table.sv
// A beat is compared in all cells in the cycle it is taken, then the flags are
// scanned one table position per cycle while the response side does not stall.
// An operation ends at the latest when the scan reaches the end of the held entries.
// Throughput: one request at a time; the chain of cells and its scan set this.
// A search sends each match once the next match or the table end is reached.
// Reset clears the entry count and control state; records need no clearing.
// ----------------------------------------------------------------------------
// sorted_key_table: key-ordered record table built as a chain of cells
// Supports insert, delete by key, find by key and find by sum. The controller
// scans compare flags that shift out of the chain and commits shifts in place.
// ----------------------------------------------------------------------------
module sorted_key_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [31:0]                  req_member_key,
   input  logic [15:0]                  req_count_q0,
   input  logic [15:0]                  req_count_q1,
   input  logic [15:0]                  req_count_q2,
   input  logic [15:0]                  req_count_q3,
   input  logic [17:0]                  req_wanted_sum,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [5:0]                   rsp_entry_index,
   output logic [6:0]                   rsp_entry_count,
   output logic                         rsp_last_result
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam int N = skt_pkg::CAPACITY;

   state_type                        state_ff, state_in;
   skt_pkg::op_type                  op_ff, op_in;
   skt_pkg::record_type              new_rec_ff, new_rec_in;
   logic [skt_pkg::COUNT_W-1:0]      held_ff, held_in;
   logic [skt_pkg::COUNT_W-1:0]      scan_ff, scan_in;
   logic                             pend_valid_ff, pend_valid_in;
   logic [skt_pkg::IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   skt_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [skt_pkg::IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [skt_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                             rsp_last_ff, rsp_last_in;

   skt_pkg::cell_ctrl_type           ctrl;
   skt_pkg::record_type              cell_rec [N];
   skt_pkg::flag_type                cell_flags [N];
   skt_pkg::record_type              left_rec [N];
   skt_pkg::record_type              right_rec [N];
   skt_pkg::flag_type                right_flags [N];

   logic                             accept;
   logic                             out_free;
   logic                             at_end;
   logic                             full;
   logic                             do_ins;
   logic                             do_del;
   logic [skt_pkg::IDX_W-1:0]        pos;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_end   = scan_ff == held_ff;
   assign full     = held_ff == skt_pkg::COUNT_W'(N);
   assign pos      = scan_ff[skt_pkg::IDX_W-1:0];

   // Controller: takes a beat, scans the flags and emits responses.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      new_rec_in    = new_rec_ff;
      held_in       = held_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      do_ins        = 1'b0;
      do_del        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in             = skt_pkg::op_type'(req_operation);
               new_rec_in.key    = req_member_key;
               new_rec_in.counts = {req_count_q3, req_count_q2, req_count_q1, req_count_q0};
               new_rec_in.sum    = skt_pkg::SUM_W'(req_count_q0) + skt_pkg::SUM_W'(req_count_q1)
                                 + skt_pkg::SUM_W'(req_count_q2) + skt_pkg::SUM_W'(req_count_q3);
               scan_in           = '0;
               pend_valid_in     = 1'b0;
               state_in          = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               rsp_count_in = held_ff;
               rsp_last_in  = 1'b1;
               case (op_ff)
                  skt_pkg::OP_INSERT: begin
                     if (!at_end && cell_flags[0].hit) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skt_pkg::STATUS_DUP;
                        rsp_index_in  = pos;
                        state_in      = ST_IDLE;
                     end else if (at_end || cell_flags[0].gt) begin
                        rsp_valid_in = 1'b1;
                        state_in     = ST_IDLE;
                        if (full) begin
                           rsp_status_in = skt_pkg::STATUS_FULL;
                           rsp_index_in  = '0;
                        end else begin
                           do_ins        = 1'b1;
                           held_in       = held_ff + 1'b1;
                           rsp_status_in = skt_pkg::STATUS_OK;
                           rsp_index_in  = pos;
                           rsp_count_in  = held_ff + 1'b1;
                        end
                     end else begin
                        scan_in = scan_ff + 1'b1;
                     end
                  end
                  skt_pkg::OP_DELETE: begin
                     if (!at_end && cell_flags[0].hit) begin
                        do_del        = 1'b1;
                        held_in       = held_ff - 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skt_pkg::STATUS_OK;
                        rsp_index_in  = pos;
                        rsp_count_in  = held_ff - 1'b1;
                        state_in      = ST_IDLE;
                     end else if (at_end || cell_flags[0].gt) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = skt_pkg::STATUS_MISSING;
                        rsp_index_in  = '0;
                        state_in      = ST_IDLE;
                     end else begin
                        scan_in = scan_ff + 1'b1;
                     end
                  end
                  default: begin
                     // Searches hold the latest match back until the next one
                     // or the end shows whether it is the last.
                     if (at_end) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pend_valid_ff ? skt_pkg::STATUS_OK
                                                      : skt_pkg::STATUS_MISSING;
                        rsp_index_in  = pend_valid_ff ? pend_idx_ff : '0;
                        pend_valid_in = 1'b0;
                        state_in      = ST_IDLE;
                     end else begin
                        if (cell_flags[0].hit) begin
                           rsp_valid_in  = pend_valid_ff;
                           rsp_status_in = skt_pkg::STATUS_OK;
                           rsp_index_in  = pend_idx_ff;
                           rsp_last_in   = 1'b0;
                           pend_valid_in = 1'b1;
                           pend_idx_in   = pos;
                        end
                        scan_in = scan_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      new_rec_ff    <= new_rec_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Broadcast control to the chain.
   always_comb begin
      ctrl.load     = accept;
      ctrl.by_sum   = skt_pkg::op_type'(req_operation) == skt_pkg::OP_FIND_SUM;
      ctrl.want_key = req_member_key;
      ctrl.want_sum = req_wanted_sum;
      ctrl.scan     = (state_ff == ST_SCAN) && out_free;
      ctrl.ins      = do_ins;
      ctrl.del      = do_del;
      ctrl.pos      = pos;
      ctrl.new_rec  = new_rec_ff;
   end

   // Chain of cells with neighbor links; the ends see empty neighbors.
   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_rec[g] = '0;
      end else begin : g_mid_l
         assign left_rec[g] = cell_rec[g-1];
      end
      if (g == N - 1) begin : g_last
         assign right_rec[g]   = '0;
         assign right_flags[g] = '0;
      end else begin : g_mid_r
         assign right_rec[g]   = cell_rec[g+1];
         assign right_flags[g] = cell_flags[g+1];
      end
      skt_cell u_cell (
         .clock       (clock),
         .my_pos      (skt_pkg::IDX_W'(g)),
         .ctrl        (ctrl),
         .left_rec    (left_rec[g]),
         .right_rec   (right_rec[g]),
         .right_flags (right_flags[g]),
         .rec         (cell_rec[g]),
         .flags       (cell_flags[g])
      );
   end

   assign req_stall       = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
